### src/lph_pkg.sv
// Shared types, widths and codes of the linear probing key/value table.
package lph_pkg;

	localparam int KEY_W   = 64;
	localparam int VAL_W   = 64;
	localparam int HASH_W  = 32;
	localparam int CMD_W   = 2;
	localparam int STAT_W  = 2;
	localparam int COUNT_W = 9;
	localparam int SLOTS_DEFAULT = 256;

	localparam logic [CMD_W-1:0] CMD_GET    = 2'd0;
	localparam logic [CMD_W-1:0] CMD_SET    = 2'd1;
	localparam logic [CMD_W-1:0] CMD_REMOVE = 2'd2;
	localparam logic [CMD_W-1:0] CMD_CLEAR  = 2'd3;

	localparam logic [STAT_W-1:0] ST_OK     = 2'd0;
	localparam logic [STAT_W-1:0] ST_ABSENT = 2'd1;
	localparam logic [STAT_W-1:0] ST_FULL   = 2'd2;

	typedef struct packed {
		logic              used;
		logic [HASH_W-1:0] hash;
		logic [KEY_W-1:0]  key;
		logic [VAL_W-1:0]  value;
	} entry_t;

endpackage

### src/lph_mod.sv
// Reduces a 32-bit hash to its home slot, hash modulo the slot count.
module lph_mod import lph_pkg::*; #(
	parameter int SLOTS = SLOTS_DEFAULT
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       start,
	input  logic [HASH_W-1:0]          hash_in,
	output logic                       done,
	output logic [$clog2(SLOTS)-1:0]   rem
);
	localparam int IDX_W = $clog2(SLOTS);
	localparam bit POW2  = (SLOTS & (SLOTS - 1)) == 0;

	generate
		if (POW2) begin : g_mask
			logic             done_q;
			logic [IDX_W-1:0] rem_q;
			always_ff @(posedge clk or negedge arst_n) begin
				if (!arst_n) begin
					done_q <= 1'b0;
				end else begin
					done_q <= start;
				end
			end
			always_ff @(posedge clk) begin
				if (start) begin
					rem_q <= hash_in[IDX_W-1:0];
				end
			end
			assign done = done_q;
			assign rem  = rem_q;
		end else begin : g_recip
			// Reciprocal multiplication: the quotient estimate is exact or one short, so a
			// single conditional subtraction finishes the remainder.
			localparam logic [HASH_W-1:0] RECIP = HASH_W'(64'h1_0000_0000 / SLOTS);
			logic                v_s1;
			logic                v_s2;
			logic                done_q;
			logic [2*HASH_W-1:0] prod_s1;
			logic [HASH_W-1:0]   hash_s1;
			logic [HASH_W-1:0]   qs;
			logic [IDX_W:0]      raw_s2;
			logic [IDX_W:0]      fixed;
			logic [IDX_W-1:0]    rem_q;
			assign qs    = prod_s1[2*HASH_W-1:HASH_W] * HASH_W'(SLOTS);
			assign fixed = (raw_s2 >= (IDX_W+1)'(SLOTS)) ? raw_s2 - (IDX_W+1)'(SLOTS) : raw_s2;
			always_ff @(posedge clk or negedge arst_n) begin
				if (!arst_n) begin
					v_s1   <= 1'b0;
					v_s2   <= 1'b0;
					done_q <= 1'b0;
				end else begin
					v_s1   <= start;
					v_s2   <= v_s1;
					done_q <= v_s2;
				end
			end
			always_ff @(posedge clk) begin
				prod_s1 <= (2*HASH_W)'(hash_in) * (2*HASH_W)'(RECIP);
				hash_s1 <= hash_in;
				raw_s2  <= (IDX_W+1)'(hash_s1 - qs);
				rem_q   <= fixed[IDX_W-1:0];
			end
			assign done = done_q;
			assign rem  = rem_q;
		end
	endgenerate
endmodule

### src/lph_mem.sv
// Entry store: hash, key and value of every slot, one write and one read port.
module lph_mem import lph_pkg::*; #(
	parameter int SLOTS = SLOTS_DEFAULT
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(SLOTS)-1:0] waddr,
	input  entry_t                   wdata,
	input  logic                     re,
	input  logic [$clog2(SLOTS)-1:0] raddr,
	output entry_t                   rdata
);
	entry_t mem [SLOTS];
	entry_t rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (re) begin
			rdata_q <= mem[raddr];
		end
	end

	assign rdata = rdata_q;
endmodule

### src/linear_probe_hash_table.sv
// Linear probing key/value table: top level with the command sequencer.
//
// Each input item carries a command (get, set, remove or clear), a 64-bit key, the key's
// 32-bit hash and a 64-bit value, and gives exactly one result item with a status, the
// value found by get and the number of occupied slots. Occupied flags, keys, values and
// hashes live in one synchronous memory, so every slot visit is a read followed by a
// check. After reset the block runs a clearing pass over every slot before it takes its
// first item, and clear runs the same pass. The block works on one item at a time. The
// home slot is found by the modulo unit: by masking when SLOTS is a power of two, by
// reciprocal multiplication otherwise. A get or set is accepted, its home slot is found,
// slots are visited from there until it meets its key or a free slot or has tried every
// slot, and its result is handed over. Remove additionally walks the entries that follow
// the freed slot: each is read and taken out, its home slot is found, and slots are
// visited from there until a free one takes it back; the walk ends on the first free
// slot or when it comes back round to the freed slot. A finished result goes to the
// output register; while an earlier result still waits there, the next item is worked
// on and then waits for the output register to free, so input items are taken while a
// result waits.
module linear_probe_hash_table import lph_pkg::*; #(
	parameter int SLOTS = SLOTS_DEFAULT
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic [CMD_W-1:0]   command,
	input  logic [KEY_W-1:0]   key,
	input  logic [HASH_W-1:0]  key_digest,
	input  logic [VAL_W-1:0]   value_in,
	output logic               out_valid,
	input  logic               out_ready,
	output logic [STAT_W-1:0]  status,
	output logic [VAL_W-1:0]   value_out,
	output logic [COUNT_W-1:0] entry_count
);
	localparam int IDX_W = $clog2(SLOTS);
	localparam int CNT_W = $clog2(SLOTS + 1);
	localparam int ST_W  = 4;

	localparam logic [ST_W-1:0] S_IDLE   = 4'd0;
	localparam logic [ST_W-1:0] S_HASH   = 4'd1;
	localparam logic [ST_W-1:0] S_PRB    = 4'd2;
	localparam logic [ST_W-1:0] S_CMP    = 4'd3;
	localparam logic [ST_W-1:0] S_RCHK   = 4'd4;
	localparam logic [ST_W-1:0] S_RRD    = 4'd5;
	localparam logic [ST_W-1:0] S_RHASH  = 4'd6;
	localparam logic [ST_W-1:0] S_RWALK  = 4'd7;
	localparam logic [ST_W-1:0] S_OUT    = 4'd8;
	localparam logic [ST_W-1:0] S_RWCHK  = 4'd9;
	localparam logic [ST_W-1:0] S_CLR    = 4'd10;

	logic [ST_W-1:0]    state_q;
	logic [CNT_W-1:0]   count_q;
	logic [IDX_W-1:0]   clr_q;
	logic               init_q;

	// The item under work.
	logic [CMD_W-1:0]   cmd_q;
	logic [KEY_W-1:0]   key_q;
	logic [HASH_W-1:0]  hash_q;
	logic [VAL_W-1:0]   val_q;

	// Probe position, slots visited, and the remove walk's hole and cursor.
	logic [IDX_W-1:0]   pos_q;
	logic [CNT_W-1:0]   visits_q;
	logic [IDX_W-1:0]   hole_q;
	logic [IDX_W-1:0]   nxt_q;
	entry_t             moved_q;

	logic [STAT_W-1:0]  res_status_q;
	logic [VAL_W-1:0]   res_value_q;

	logic               out_valid_q;
	logic [STAT_W-1:0]  status_q;
	logic [VAL_W-1:0]   value_out_q;
	logic [COUNT_W-1:0] entry_count_q;

	logic               mod_start;
	logic [HASH_W-1:0]  mod_hash;
	logic               mod_done;
	logic [IDX_W-1:0]   mod_rem;

	logic               mem_we;
	logic [IDX_W-1:0]   mem_waddr;
	entry_t             mem_wdata;
	logic               mem_re;
	logic [IDX_W-1:0]   mem_raddr;
	entry_t             mem_rdata;

	logic               accept;
	logic               hit;
	logic               out_load;

	function automatic logic [IDX_W-1:0] step(input logic [IDX_W-1:0] p);
		step = (p == IDX_W'(SLOTS - 1)) ? '0 : p + 1'b1;
	endfunction

	assign accept   = in_valid && in_ready;
	assign in_ready = (state_q == S_IDLE);
	assign hit      = mem_rdata.used && (mem_rdata.hash == hash_q) && (mem_rdata.key == key_q);
	assign out_load = (state_q == S_OUT) && (!out_valid_q || out_ready);

	// The modulo unit serves the probe of a new item and each reinsertion after a remove.
	assign mod_start = (accept && (command != CMD_CLEAR)) ||
	                   ((state_q == S_RRD) && mem_rdata.used);
	assign mod_hash  = (state_q == S_RRD) ? mem_rdata.hash : key_digest;

	lph_mod #(.SLOTS(SLOTS)) u_mod (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (mod_start),
		.hash_in (mod_hash),
		.done    (mod_done),
		.rem     (mod_rem)
	);

	// Reads: the probed slot, the slot tried for a reinsertion, or the entry following
	// the hole during a remove. No read ever meets a write to the same slot in one cycle.
	assign mem_re    = (state_q == S_PRB) || (state_q == S_RWALK) ||
	                   ((state_q == S_RCHK) && (nxt_q != hole_q));
	assign mem_raddr = (state_q == S_RCHK) ? nxt_q : pos_q;

	// Writes: a new or updated entry, a freed slot, a moved entry, or the clearing pass.
	always_comb begin
		mem_we    = 1'b0;
		mem_waddr = pos_q;
		mem_wdata = '{used: 1'b1, hash: hash_q, key: key_q, value: val_q};
		case (state_q)
			S_CMP: begin
				mem_we = ((cmd_q == CMD_SET) && (!mem_rdata.used || hit)) ||
				         ((cmd_q == CMD_REMOVE) && hit);
				mem_wdata.used = (cmd_q == CMD_SET);
			end
			S_RRD: begin
				mem_we         = mem_rdata.used;
				mem_waddr      = nxt_q;
				mem_wdata      = mem_rdata;
				mem_wdata.used = 1'b0;
			end
			S_RWCHK: begin
				mem_we    = !mem_rdata.used;
				mem_wdata = moved_q;
			end
			S_CLR: begin
				mem_we         = 1'b1;
				mem_waddr      = clr_q;
				mem_wdata.used = 1'b0;
			end
			default: begin
				mem_we = 1'b0;
			end
		endcase
	end

	lph_mem #(.SLOTS(SLOTS)) u_mem (
		.clk   (clk),
		.we    (mem_we),
		.waddr (mem_waddr),
		.wdata (mem_wdata),
		.re    (mem_re),
		.raddr (mem_raddr),
		.rdata (mem_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_CLR;
			count_q     <= '0;
			clr_q       <= '0;
			init_q      <= 1'b1;
			out_valid_q <= 1'b0;
		end else begin
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (accept) begin
						if (command == CMD_CLEAR) begin
							count_q <= '0;
							state_q <= S_CLR;
						end else begin
							state_q <= S_HASH;
						end
					end
				end
				S_CLR: begin
					// One slot is freed per cycle; after reset no result item follows.
					if (clr_q == IDX_W'(SLOTS - 1)) begin
						clr_q   <= '0;
						init_q  <= 1'b0;
						state_q <= init_q ? S_IDLE : S_OUT;
					end else begin
						clr_q <= clr_q + 1'b1;
					end
				end
				S_HASH: begin
					if (mod_done) begin
						state_q <= S_PRB;
					end
				end
				S_PRB: begin
					state_q <= S_CMP;
				end
				S_CMP: begin
					if (!mem_rdata.used) begin
						// A free slot ends the probe: set fills it, the others miss.
						if (cmd_q == CMD_SET) begin
							count_q <= count_q + 1'b1;
						end
						state_q <= S_OUT;
					end else if (hit) begin
						if (cmd_q == CMD_REMOVE) begin
							count_q <= count_q - 1'b1;
							state_q <= S_RCHK;
						end else begin
							state_q <= S_OUT;
						end
					end else if (visits_q == CNT_W'(SLOTS - 1)) begin
						state_q <= S_OUT;
					end else begin
						state_q <= S_PRB;
					end
				end
				S_RCHK: begin
					if (nxt_q == hole_q) begin
						state_q <= S_OUT;
					end else begin
						state_q <= S_RRD;
					end
				end
				S_RRD: begin
					// An occupied follower is taken out; it goes back in from its home slot.
					if (!mem_rdata.used) begin
						state_q <= S_OUT;
					end else begin
						count_q <= count_q - 1'b1;
						state_q <= S_RHASH;
					end
				end
				S_RHASH: begin
					if (mod_done) begin
						state_q <= S_RWALK;
					end
				end
				S_RWALK: begin
					state_q <= S_RWCHK;
				end
				S_RWCHK: begin
					if (!mem_rdata.used) begin
						count_q <= count_q + 1'b1;
						state_q <= S_RCHK;
					end else begin
						state_q <= S_RWALK;
					end
				end
				S_OUT: begin
					if (out_load) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// Payload and work registers.
	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				if (accept) begin
					cmd_q        <= command;
					key_q        <= key;
					hash_q       <= key_digest;
					val_q        <= value_in;
					visits_q     <= '0;
					res_status_q <= ST_OK;
					res_value_q  <= '0;
				end
			end
			S_HASH: begin
				if (mod_done) begin
					pos_q <= mod_rem;
				end
			end
			S_CMP: begin
				if (!mem_rdata.used) begin
					if (cmd_q != CMD_SET) begin
						res_status_q <= ST_ABSENT;
					end
				end else if (hit) begin
					if (cmd_q == CMD_GET) begin
						res_value_q <= mem_rdata.value;
					end
					hole_q <= pos_q;
					nxt_q  <= step(pos_q);
				end else begin
					pos_q    <= step(pos_q);
					visits_q <= visits_q + 1'b1;
					if (visits_q == CNT_W'(SLOTS - 1)) begin
						res_status_q <= (cmd_q == CMD_SET) ? ST_FULL : ST_ABSENT;
					end
				end
			end
			S_RRD: begin
				moved_q <= mem_rdata;
			end
			S_RHASH: begin
				if (mod_done) begin
					pos_q <= mod_rem;
				end
			end
			S_RWCHK: begin
				if (!mem_rdata.used) begin
					nxt_q <= step(nxt_q);
				end else begin
					pos_q <= step(pos_q);
				end
			end
			S_OUT: begin
				if (out_load) begin
					status_q      <= (cmd_q == CMD_CLEAR) ? ST_OK : res_status_q;
					value_out_q   <= (cmd_q == CMD_CLEAR) ? '0 : res_value_q;
					entry_count_q <= COUNT_W'(count_q);
				end
			end
			default: begin
				pos_q <= pos_q;
			end
		endcase
	end

	assign out_valid   = out_valid_q;
	assign status      = status_q;
	assign value_out   = value_out_q;
	assign entry_count = entry_count_q;

	// The occupancy count never passes the slot count.
	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(SLOTS))
		else $error("entry count above slot count");

	// A clear empties the count by the next edge.
	a_clear: assert property (@(posedge clk) disable iff (!arst_n)
		accept && (command == CMD_CLEAR) |=> (count_q == '0))
		else $error("clear left occupied slots");

	// Only one command is under work: no item is taken outside the idle state.
	a_one_item: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != S_IDLE) |-> !in_ready)
		else $error("item taken while busy");

	// A waiting result item stays valid and unchanged until it is taken.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && !out_ready |=> out_valid_q && $stable(status_q) &&
			$stable(value_out_q) && $stable(entry_count_q))
		else $error("result item changed while waiting");
endmodule

### tb/tb_linear_probe_hash_table.sv
// Self-checking testbench of the linear probing key/value table: directed, fill and random items.
`timescale 1ns / 1ps

module tb_linear_probe_hash_table;
	import lph_pkg::*;

	localparam int NSLOTS      = 256;
	localparam int CYCLE_LIMIT = 20000000;
	localparam int POOL_N      = 40;

	// One expected result item, as the table should report it.
	typedef struct {
		logic [STAT_W-1:0]  status;
		logic [VAL_W-1:0]   value;
		logic [COUNT_W-1:0] count;
	} table_reply_t;

	// The scoreboard keeps its own copy of the table and predicts each reply.
	class table_scoreboard;
		bit                used [NSLOTS];
		logic [KEY_W-1:0]  skey [NSLOTS];
		logic [VAL_W-1:0]  sval [NSLOTS];
		logic [HASH_W-1:0] shash[NSLOTS];
		int unsigned       occupied;
		table_reply_t      pending[$];
		int unsigned       errors;

		function new();
			foreach (used[i]) used[i] = 0;
			occupied = 0;
			errors = 0;
		endfunction

		task report(input string what);
			$display("MISMATCH at %0t: %s", $realtime, what);
			errors++;
		endtask

		function int find_slot(logic [KEY_W-1:0] k, logic [HASH_W-1:0] h);
			int pos;
			pos = h % NSLOTS;
			for (int n = 0; n < NSLOTS; n++) begin
				if (!used[pos]) return pos;
				if (shash[pos] == h && skey[pos] == k) return pos;
				pos = (pos + 1) % NSLOTS;
			end
			return -1;
		endfunction

		function bit store(logic [KEY_W-1:0] k, logic [HASH_W-1:0] h, logic [VAL_W-1:0] v);
			int p;
			p = find_slot(k, h);
			if (p < 0) return 0;
			if (!used[p]) begin
				skey[p] = k;
				shash[p] = h;
				used[p] = 1;
				occupied++;
			end
			sval[p] = v;
			return 1;
		endfunction

		// Called for every accepted input item.
		function void note_command(logic [CMD_W-1:0] cmd, logic [KEY_W-1:0] k,
				logic [HASH_W-1:0] h, logic [VAL_W-1:0] v);
			table_reply_t r;
			int p, hole, nxt;
			logic [KEY_W-1:0] mk;
			logic [VAL_W-1:0] mv;
			logic [HASH_W-1:0] mh;
			bit ok;
			r.status = ST_OK;
			r.value = '0;
			case (cmd)
				CMD_GET: begin
					p = find_slot(k, h);
					if (p >= 0 && used[p]) r.value = sval[p];
					else r.status = ST_ABSENT;
				end
				CMD_SET: begin
					if (!store(k, h, v)) r.status = ST_FULL;
				end
				CMD_REMOVE: begin
					p = find_slot(k, h);
					if (p >= 0 && used[p]) begin
						hole = p;
						nxt = (hole + 1) % NSLOTS;
						used[hole] = 0;
						occupied--;
						while (nxt != hole && used[nxt]) begin
							mk = skey[nxt];
							mv = sval[nxt];
							mh = shash[nxt];
							used[nxt] = 0;
							occupied--;
							ok = store(mk, mh, mv);
							nxt = (nxt + 1) % NSLOTS;
						end
					end else begin
						r.status = ST_ABSENT;
					end
				end
				default: begin
					foreach (used[i]) used[i] = 0;
					occupied = 0;
				end
			endcase
			r.count = occupied[COUNT_W-1:0];
			pending.push_back(r);
		endfunction

		// Called for every accepted result item.
		task check_reply(logic [STAT_W-1:0] st, logic [VAL_W-1:0] v, logic [COUNT_W-1:0] c);
			table_reply_t e;
			if (pending.size() == 0) begin
				report("result item with nothing expected");
			end else begin
				e = pending.pop_front();
				if (st !== e.status)
					report($sformatf("status %0d, expected %0d", st, e.status));
				if (v !== e.value)
					report($sformatf("value_out %h, expected %h", v, e.value));
				if (c !== e.count)
					report($sformatf("entry_count %0d, expected %0d", c, e.count));
			end
		endtask
	endclass

	logic               clk;
	logic               arst_n;
	logic               in_valid;
	logic               in_ready;
	logic [CMD_W-1:0]   command;
	logic [KEY_W-1:0]   key;
	logic [HASH_W-1:0]  key_digest;
	logic [VAL_W-1:0]   value_in;
	logic               out_valid;
	logic               out_ready;
	logic [STAT_W-1:0]  status;
	logic [VAL_W-1:0]   value_out;
	logic [COUNT_W-1:0] entry_count;

	table_scoreboard sb;
	bit              no_idle;      // when set, both sides run without gaps
	longint          cycles;
	logic [KEY_W-1:0]  pool_key [POOL_N];
	logic [HASH_W-1:0] pool_hash[POOL_N];

	linear_probe_hash_table #(.SLOTS(NSLOTS)) i_dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready),
		.command(command), .key(key), .key_digest(key_digest), .value_in(value_in),
		.out_valid(out_valid), .out_ready(out_ready),
		.status(status), .value_out(value_out), .entry_count(entry_count)
	);

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	// A cycle counter guards against a hung block.
	initial begin
		cycles = 0;
		forever begin
			@(posedge clk);
			cycles++;
			if (cycles > CYCLE_LIMIT) begin
				$display("Testbench completed WITH ERRORS");
				$finish;
			end
		end
	end

	function automatic int draw_gap();
		if (no_idle) return 0;
		return $urandom_range(0, 7);
	endfunction

	// Presents one input item and returns once it has been accepted. The valid line is
	// only lowered when a gap is drawn, so a back-to-back item never sees it drop.
	// Ready only changes at rising edges, so its value at the falling edge is the one
	// that the next rising edge sees.
	task automatic send_item(logic [CMD_W-1:0] c, logic [KEY_W-1:0] k,
			logic [HASH_W-1:0] h, logic [VAL_W-1:0] v);
		int gap;
		bit ready_seen;
		gap = draw_gap();
		@(negedge clk);
		if (gap != 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		command    <= c;
		key        <= k;
		key_digest <= h;
		value_in   <= v;
		in_valid   <= 1'b1;
		forever begin
			ready_seen = in_ready;
			@(posedge clk);
			if (ready_seen) break;
			@(negedge clk);
		end
		sb.note_command(c, k, h, v);
	endtask

	// The receiving side takes result items with its own random stalls. The result is
	// captured at the falling edge, where it holds the value that the rising edge takes.
	task automatic take_results();
		int gap;
		bit valid_seen;
		logic [STAT_W-1:0]  st;
		logic [VAL_W-1:0]   v;
		logic [COUNT_W-1:0] c;
		forever begin
			gap = draw_gap();
			@(negedge clk);
			if (gap != 0) begin
				out_ready <= 1'b0;
				repeat (gap) @(negedge clk);
			end
			out_ready <= 1'b1;
			forever begin
				valid_seen = out_valid;
				st = status;
				v = value_out;
				c = entry_count;
				@(posedge clk);
				if (valid_seen) break;
				@(negedge clk);
			end
			sb.check_reply(st, v, c);
		end
	endtask

	function automatic logic [63:0] rand64();
		return {$urandom(), $urandom()};
	endfunction

	// Hashes are clustered on a few home slots, some near the top so that probes wrap.
	function automatic logic [HASH_W-1:0] clustered_hash();
		logic [7:0] home;
		if ($urandom_range(0, 3) == 0) home = 8'(248 + $urandom_range(0, 7));
		else home = 8'($urandom_range(0, 23));
		return {24'($urandom()), home};
	endfunction

	task automatic random_item();
		int sel, i;
		logic [CMD_W-1:0] c;
		sel = $urandom_range(0, 99);
		i = $urandom_range(0, POOL_N - 1);
		if (sel < 40) c = CMD_SET;
		else if (sel < 70) c = CMD_GET;
		else if (sel < 98) c = CMD_REMOVE;
		else c = CMD_CLEAR;
		case ($urandom_range(0, 9))
			0: send_item(c, rand64(), clustered_hash(), rand64());
			1: send_item(c, pool_key[i], pool_hash[i] ^ 32'h100, rand64());
			default: send_item(c, pool_key[i], pool_hash[i], rand64());
		endcase
	endtask

	initial begin
		logic [KEY_W-1:0] fk;
		sb = new();
		no_idle = 0;
		arst_n = 1'b0;
		in_valid = 1'b0;
		out_ready = 1'b0;
		command = CMD_GET;
		key = '0;
		key_digest = '0;
		value_in = '0;
		for (int i = 0; i < POOL_N; i++) begin
			pool_key[i] = rand64();
			// Every fifth key shares the hash of its neighbour, so equal hashes
			// with different keys are common.
			pool_hash[i] = (i % 5 == 4) ? pool_hash[i - 1] : clustered_hash();
		end
		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		fork
			take_results();
		join_none

		// Directed part: empty table, extreme keys and hashes, update, collision,
		// absent removal, removal with a follower, clear.
		send_item(CMD_GET,    '0, '0, '0);
		send_item(CMD_REMOVE, '0, '0, '0);
		send_item(CMD_SET,    '0, '0, '0);
		send_item(CMD_SET,    '1, '1, '1);
		send_item(CMD_GET,    '0, '0, '1);
		send_item(CMD_GET,    '1, '1, '0);
		send_item(CMD_SET,    '0, '0, 64'hA5A5_5A5A_F00D_BEEF);
		send_item(CMD_GET,    '0, '0, '0);
		send_item(CMD_SET,    64'd7, '0, 64'd70);
		send_item(CMD_SET,    64'd9, 32'h0000_01FF, 64'd90);
		send_item(CMD_GET,    64'd7, 32'h0000_0100, '0);
		send_item(CMD_REMOVE, 64'd5, '0, '0);
		send_item(CMD_REMOVE, '0, '0, '0);
		send_item(CMD_GET,    64'd7, '0, '0);
		send_item(CMD_GET,    64'd9, 32'h0000_01FF, '0);
		send_item(CMD_REMOVE, '1, '1, '0);
		send_item(CMD_GET,    64'd9, 32'h0000_01FF, '0);
		send_item(CMD_CLEAR,  '1, '1, '1);
		send_item(CMD_GET,    64'd7, '0, '0);

		// Fill the table, overflow it, probe a full table, then free one slot and
		// let the removal walk the whole table.
		no_idle = 1;
		for (int i = 0; i < NSLOTS; i++)
			send_item(CMD_SET, 64'h1000 + i, clustered_hash(), rand64());
		no_idle = 0;
		send_item(CMD_SET,    64'hDEAD, 32'h55, 64'd1);
		send_item(CMD_GET,    64'hDEAD, 32'h55, '0);
		send_item(CMD_REMOVE, 64'hDEAD, 32'h55, '0);
		send_item(CMD_SET,    64'h1005, 32'h5, 64'd2);
		fk = 64'h1000 + $urandom_range(0, NSLOTS - 1);
		for (int s = 0; s < NSLOTS; s++)
			if (sb.used[s] && sb.skey[s] == fk) send_item(CMD_REMOVE, fk, sb.shash[s], '0);
		send_item(CMD_SET,    64'hDEAD, 32'h55, 64'd3);
		send_item(CMD_CLEAR,  '0, '0, '0);

		// Random part, with a burst without gaps in the middle.
		for (int n = 0; n < 1450; n++) begin
			no_idle = (n >= 800 && n < 950);
			random_item();
		end
		no_idle = 0;

		@(negedge clk);
		in_valid <= 1'b0;
		while (sb.pending.size() != 0) @(posedge clk);
		repeat (100) @(posedge clk);
		if (sb.errors == 0 && sb.pending.size() == 0) begin
			$display("Testbench completed without errors");
		end else begin
			$display("Testbench completed WITH ERRORS");
		end
		$finish;
	end

endmodule
